// File: sv/qpr_pkg.sv
// Shared types, widths and rounding helpers for the quaternion pose rate unit.
// Every RTL file of the unit imports this package; it depends on nothing else.
`default_nettype none

package qpr_pkg;

  // Widths of the fixed-point intermediates.
  localparam int unsigned WordW = 32;
  localparam int unsigned QuatProdW = 64;   // Q2.30 times Q2.30, exact
  localparam int unsigned RotW = 66;        // rotation matrix entry, Q.60 with factor two
  localparam int unsigned RotLoW = 33;      // low slice of a rotation entry
  localparam int unsigned RotDotW = 100;    // three rotation products summed, Q.76
  localparam int unsigned RateSumW = 66;    // three quaternion rate products summed, Q.46
  localparam int unsigned PosShift = 60;
  localparam int unsigned QuatShift = 31;   // includes the factor one half

  localparam logic [WordW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] SatMin = 32'h8000_0000;

  // One input item: orientation and body velocity.
  typedef struct packed {
    logic signed [WordW-1:0] quat_s;
    logic signed [WordW-1:0] quat_x;
    logic signed [WordW-1:0] quat_y;
    logic signed [WordW-1:0] quat_z;
    logic signed [WordW-1:0] lin_vel_x;
    logic signed [WordW-1:0] lin_vel_y;
    logic signed [WordW-1:0] lin_vel_z;
    logic signed [WordW-1:0] ang_vel_x;
    logic signed [WordW-1:0] ang_vel_y;
    logic signed [WordW-1:0] ang_vel_z;
  } pose_t;

  // One result item: world position rate and quaternion rate.
  typedef struct packed {
    logic signed [WordW-1:0] pos_rate_x;
    logic signed [WordW-1:0] pos_rate_y;
    logic signed [WordW-1:0] pos_rate_z;
    logic signed [WordW-1:0] quat_rate_s;
    logic signed [WordW-1:0] quat_rate_x;
    logic signed [WordW-1:0] quat_rate_y;
    logic signed [WordW-1:0] quat_rate_z;
  } rate_t;

  // Load enables for the back half of the pipeline.
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // Round half up at bit 60 and saturate a rotation dot product to 32 bits.
  function automatic logic signed [WordW-1:0] round_sat_pos(
    input logic signed [RotDotW-1:0] v
  );
    logic signed [RotDotW-1:0] b;
    logic signed [RotDotW-PosShift-1:0] q;
    logic signed [WordW-1:0] r;
    b = v + (RotDotW'(1) << (PosShift - 1));
    q = b[RotDotW-1:PosShift];
    if (q[RotDotW-PosShift-1:WordW-1] !=
        {(RotDotW-PosShift-WordW+1){q[RotDotW-PosShift-1]}}) begin
      r = q[RotDotW-PosShift-1] ? SatMin : SatMax;
    end else begin
      r = q[WordW-1:0];
    end
    return r;
  endfunction

  // Round half up at bit 31 and saturate a quaternion rate sum to 32 bits.
  function automatic logic signed [WordW-1:0] round_sat_quat(
    input logic signed [RateSumW-1:0] v
  );
    logic signed [RateSumW-1:0] b;
    logic signed [RateSumW-QuatShift-1:0] q;
    logic signed [WordW-1:0] r;
    b = v + (RateSumW'(1) << (QuatShift - 1));
    q = b[RateSumW-1:QuatShift];
    if (q[RateSumW-QuatShift-1:WordW-1] !=
        {(RateSumW-QuatShift-WordW+1){q[RateSumW-QuatShift-1]}}) begin
      r = q[RateSumW-QuatShift-1] ? SatMin : SatMax;
    end else begin
      r = q[WordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/quaternion_pose_rate_unit.sv
// Quaternion pose rate unit: position rate R(q)*v and quaternion rate 0.5*U(q)*w.
// Five register stages: an accepted item passes through stages one to five in order,
// and its result is shown from the stage five output register. Throughput is one item per
// cycle unless rate_ready stalls; each stage holds one item and fills bubbles under stall.
// Every stage advances whenever the stage after it is empty or moving, so no gap is needed.
// Synchronous reset clears only the stage valid bits; the data registers are not reset.
`default_nettype none

module quaternion_pose_rate_unit
  import qpr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  pose_valid,
  output logic       pose_ready,
  input  wire pose_t pose,
  output logic       rate_valid,
  input  wire logic  rate_ready,
  output rate_t      rate
);

  // Stage valid bits and per-stage load enables.
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  stage_en_t en;

  assign rdy5 = ~v5 | rate_ready;
  assign rdy4 = ~v4 | rdy5;
  assign rdy3 = ~v3 | rdy4;
  assign rdy2 = ~v2 | rdy3;
  assign rdy1 = ~v1 | rdy2;
  assign pose_ready = rdy1;
  assign rate_valid = v5;
  assign en = '{s3: rdy3, s4: rdy4, s5: rdy5};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pose_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Stage one: quaternion pair products, velocities carried along.
  logic signed [QuatProdW-1:0] ss, xx, yy, zz, xy, xz, yz, sx, sy, sz;
  logic signed [WordW-1:0] s1_s, s1_x, s1_y, s1_z;
  logic signed [WordW-1:0] s1_lv [3];
  logic signed [WordW-1:0] s1_av [3];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ss <= pose.quat_s * pose.quat_s;
      xx <= pose.quat_x * pose.quat_x;
      yy <= pose.quat_y * pose.quat_y;
      zz <= pose.quat_z * pose.quat_z;
      xy <= pose.quat_x * pose.quat_y;
      xz <= pose.quat_x * pose.quat_z;
      yz <= pose.quat_y * pose.quat_z;
      sx <= pose.quat_s * pose.quat_x;
      sy <= pose.quat_s * pose.quat_y;
      sz <= pose.quat_s * pose.quat_z;
      s1_s <= pose.quat_s;
      s1_x <= pose.quat_x;
      s1_y <= pose.quat_y;
      s1_z <= pose.quat_z;
      s1_lv[0] <= pose.lin_vel_x;
      s1_lv[1] <= pose.lin_vel_y;
      s1_lv[2] <= pose.lin_vel_z;
      s1_av[0] <= pose.ang_vel_x;
      s1_av[1] <= pose.ang_vel_y;
      s1_av[2] <= pose.ang_vel_z;
    end
  end

  // Stage two: rotation matrix entries and the twelve quaternion rate products.
  logic signed [RotW-1:0] rm0 [3];
  logic signed [RotW-1:0] rm1 [3];
  logic signed [RotW-1:0] rm2 [3];
  logic signed [WordW-1:0] s2_lv [3];
  logic signed [QuatProdW-1:0] x_wx, y_wy, z_wz, s_wx, z_wy, y_wz;
  logic signed [QuatProdW-1:0] z_wx, s_wy, x_wz, y_wx, x_wy, s_wz;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rm0[0] <= RotW'(ss) + RotW'(xx) - RotW'(yy) - RotW'(zz);
      rm0[1] <= (RotW'(xy) - RotW'(sz)) <<< 1;
      rm0[2] <= (RotW'(xz) + RotW'(sy)) <<< 1;
      rm1[0] <= (RotW'(xy) + RotW'(sz)) <<< 1;
      rm1[1] <= RotW'(ss) - RotW'(xx) + RotW'(yy) - RotW'(zz);
      rm1[2] <= (RotW'(yz) - RotW'(sx)) <<< 1;
      rm2[0] <= (RotW'(xz) - RotW'(sy)) <<< 1;
      rm2[1] <= (RotW'(yz) + RotW'(sx)) <<< 1;
      rm2[2] <= RotW'(ss) - RotW'(xx) - RotW'(yy) + RotW'(zz);
      s2_lv <= s1_lv;
      x_wx <= s1_x * s1_av[0];
      y_wy <= s1_y * s1_av[1];
      z_wz <= s1_z * s1_av[2];
      s_wx <= s1_s * s1_av[0];
      z_wy <= s1_z * s1_av[1];
      y_wz <= s1_y * s1_av[2];
      z_wx <= s1_z * s1_av[0];
      s_wy <= s1_s * s1_av[1];
      x_wz <= s1_x * s1_av[2];
      y_wx <= s1_y * s1_av[0];
      x_wy <= s1_x * s1_av[1];
      s_wz <= s1_s * s1_av[2];
    end
  end

  // Stage three: quaternion rate sums, signs taken from the rate matrix.
  logic signed [RateSumW-1:0] us0, us1, us2, us3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      us0 <= -RateSumW'(x_wx) - RateSumW'(y_wy) - RateSumW'(z_wz);
      us1 <=  RateSumW'(s_wx) - RateSumW'(z_wy) + RateSumW'(y_wz);
      us2 <=  RateSumW'(z_wx) + RateSumW'(s_wy) - RateSumW'(x_wz);
      us3 <= -RateSumW'(y_wx) + RateSumW'(x_wy) + RateSumW'(s_wz);
    end
  end

  // Stage four: rounded quaternion rates. Stage five: output register.
  logic signed [WordW-1:0] qr0, qr1, qr2, qr3;
  logic signed [WordW-1:0] qo0, qo1, qo2, qo3;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      qr0 <= round_sat_quat(us0);
      qr1 <= round_sat_quat(us1);
      qr2 <= round_sat_quat(us2);
      qr3 <= round_sat_quat(us3);
    end
    if (rdy5) begin
      qo0 <= qr0;
      qo1 <= qr1;
      qo2 <= qr2;
      qo3 <= qr3;
    end
  end

  // Rotation rows times linear velocity, stages three to five.
  logic signed [WordW-1:0] pos0, pos1, pos2;

  qpr_rot_dot u_row0 (.clk(clk), .en(en), .row(rm0), .vel(s2_lv), .dot(pos0));
  qpr_rot_dot u_row1 (.clk(clk), .en(en), .row(rm1), .vel(s2_lv), .dot(pos1));
  qpr_rot_dot u_row2 (.clk(clk), .en(en), .row(rm2), .vel(s2_lv), .dot(pos2));

  // The result item gathers both output registers.
  assign rate = '{pos_rate_x: pos0, pos_rate_y: pos1, pos_rate_z: pos2,
                  quat_rate_s: qo0, quat_rate_x: qo1, quat_rate_y: qo2,
                  quat_rate_z: qo3};

endmodule

`default_nettype wire

// File: sv/qpr_rot_dot.sv
// One row of the rotation matrix times the linear velocity, over three stages.
// Depends on qpr_pkg for widths, the stage enable struct and rounding.
`default_nettype none

module qpr_rot_dot
  import qpr_pkg::*;
(
  input  wire logic                     clk,
  input  wire stage_en_t                en,
  input  wire logic signed [RotW-1:0]   row [3],
  input  wire logic signed [WordW-1:0]  vel [3],
  output logic signed [WordW-1:0]       dot
);

  logic signed [RotW-RotLoW-1:0]    hi_op [3];
  logic signed [RotLoW:0]           lo_op [3];
  logic signed [RotW-RotLoW+WordW-1:0] prod_hi [3];
  logic signed [RotLoW+1+WordW-1:0]    prod_lo [3];
  logic signed [RotDotW-1:0]        sum;
  logic signed [RotDotW-1:0]        sum_next;

  // Split each 66-bit entry so that every multiplier stays near 33 by 32 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_op[i] = row[i][RotW-1:RotLoW];
      lo_op[i] = {1'b0, row[i][RotLoW-1:0]};
    end
  end

  // Stage three: partial products.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < 3; i++) begin
        prod_hi[i] <= hi_op[i] * vel[i];
        prod_lo[i] <= lo_op[i] * vel[i];
      end
    end
  end

  // Recombine the partial products and sum the row.
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 3; i++) begin
      sum_next = sum_next + (RotDotW'(prod_hi[i]) <<< RotLoW) + RotDotW'(prod_lo[i]);
    end
  end

  // Stage four: exact sum. Stage five: rounded and saturated result.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      sum <= sum_next;
    end
    if (en.s5) begin
      dot <= round_sat_pos(sum);
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for quaternion_pose_rate_unit: random and directed pose items
// are checked against an in-bench predictor of R(q)*v and 0.5*U(q)*w with rounding.
// Depends on qpr_pkg for item types, shifts and limits and on the unit itself; nothing else.

module tb;
  import qpr_pkg::*;

  typedef enum int {WordFull, WordSmall, WordCorner, WordUnit} word_kind_e;

  // One pending pose item, the idle cycles in front of it, and whether the sender must
  // first wait for every outstanding result.
  typedef struct {
    pose_t       pose;
    int unsigned idle;
    bit          drain;
  } pose_job_t;

  localparam logic [31:0] QOne = 32'h4000_0000;   // 1.0 in Q2.30
  localparam logic [31:0] QHalf = 32'h2000_0000;  // 0.5 in Q2.30
  localparam logic [31:0] QDiag = 32'h2D41_3CCD;  // 1/sqrt(2) in Q2.30
  localparam logic [31:0] VOne = 32'h0001_0000;   // 1.0 in Q16.16
  localparam logic [31:0] WordMax = 32'h7FFF_FFFF;
  localparam logic [31:0] WordMin = 32'h8000_0000;
  localparam logic [31:0] WordOnes = 32'hFFFF_FFFF;
  localparam logic signed [127:0] WideOne = 128'sd1;
  localparam logic signed [127:0] WideMax = 128'sd2147483647;
  localparam logic signed [127:0] WideMin = -128'sd2147483648;
  localparam int unsigned RandomPoses = 1200;
  localparam int unsigned DrainPoint = 600;
  localparam int unsigned LongHold = 400;
  localparam int unsigned StuckLimit = 4000;
  localparam int unsigned TailCycles = 20;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  pose_valid = 1'b0;
  pose_t pose = '0;
  logic  pose_ready;
  logic  rate_valid;
  logic  rate_ready = 1'b0;
  rate_t rate;

  pose_job_t   pose_backlog[$];
  rate_t       pending_rates[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          send_calm = 1'b0;

  // Sender state.
  int unsigned send_idle = 0;
  bit          head_loaded = 1'b0;

  // Receiver state.
  int unsigned stall_left = 0;
  rate_t       want_rate;

  int unsigned stuck_cycles = 0;

  string rate_field[7] = '{"quat_rate_z", "quat_rate_y", "quat_rate_x", "quat_rate_s",
                           "pos_rate_z", "pos_rate_y", "pos_rate_x"};

  quaternion_pose_rate_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .pose_valid (pose_valid),
    .pose_ready (pose_ready),
    .pose       (pose),
    .rate_valid (rate_valid),
    .rate_ready (rate_ready),
    .rate       (rate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sign-extend a 32-bit word so that every product and sum below is exact.
  function automatic logic signed [127:0] widen(input logic [31:0] w);
    return {{96{w[31]}}, w};
  endfunction

  // Shift right with round half up, then clamp to the signed 32-bit range.
  function automatic logic [31:0] round_clamp(input logic signed [127:0] v, input int sh);
    logic signed [127:0] q;
    q = (v + (WideOne <<< (sh - 1))) >>> sh;
    if (q > WideMax) return SatMax;
    if (q < WideMin) return SatMin;
    return q[31:0];
  endfunction

  // Position rate from the rotation matrix and quaternion rate from the rate matrix.
  function automatic rate_t pose_rate_of(input pose_t p);
    logic signed [127:0] s, x, y, z, vx, vy, vz, wx, wy, wz;
    logic signed [127:0] ss, xx, yy, zz, xy, xz, yz, sx, sy, sz;
    logic signed [127:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    rate_t r;
    s = widen(p.quat_s);
    x = widen(p.quat_x);
    y = widen(p.quat_y);
    z = widen(p.quat_z);
    vx = widen(p.lin_vel_x);
    vy = widen(p.lin_vel_y);
    vz = widen(p.lin_vel_z);
    wx = widen(p.ang_vel_x);
    wy = widen(p.ang_vel_y);
    wz = widen(p.ang_vel_z);
    ss = s * s;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    xy = x * y;
    xz = x * z;
    yz = y * z;
    sx = s * x;
    sy = s * y;
    sz = s * z;
    r00 = ss + xx - yy - zz;
    r01 = (xy - sz) <<< 1;
    r02 = (xz + sy) <<< 1;
    r10 = (xy + sz) <<< 1;
    r11 = ss - xx + yy - zz;
    r12 = (yz - sx) <<< 1;
    r20 = (xz - sy) <<< 1;
    r21 = (yz + sx) <<< 1;
    r22 = ss - xx - yy + zz;
    r.pos_rate_x = round_clamp(r00 * vx + r01 * vy + r02 * vz, PosShift);
    r.pos_rate_y = round_clamp(r10 * vx + r11 * vy + r12 * vz, PosShift);
    r.pos_rate_z = round_clamp(r20 * vx + r21 * vy + r22 * vz, PosShift);
    r.quat_rate_s = round_clamp(-(x * wx) - y * wy - z * wz, QuatShift);
    r.quat_rate_x = round_clamp(s * wx - z * wy + y * wz, QuatShift);
    r.quat_rate_y = round_clamp(z * wx + s * wy - x * wz, QuatShift);
    r.quat_rate_z = round_clamp(-(y * wx) + x * wy + s * wz, QuatShift);
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] rand_word(input word_kind_e kind);
    logic [31:0] v;
    case (kind)
      WordSmall: begin
        v = $urandom_range(0, 32'h0010_0000);
        return $urandom_range(0, 1) ? -v : v;
      end
      WordUnit: begin
        v = $urandom_range(0, QOne);
        return $urandom_range(0, 1) ? -v : v;
      end
      WordCorner: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return 32'h1;
          2: return WordOnes;
          3: return WordMax;
          4: return WordMin;
          default: return QOne;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Append a pose item; runs of items without idling alternate with idling runs.
  task automatic queue_pose(input pose_t p, input bit drain);
    pose_job_t j;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    j.pose = p;
    j.idle = send_calm ? 0 : pick_idle();
    j.drain = drain;
    pose_backlog.push_back(j);
  endtask

  // Sender: offers the head of the backlog after its idle cycles (for a drain item, once no
  // result is outstanding) and records the expected result when an item is taken.
  always @(posedge clk) begin
    if (rst) begin
      pose_valid <= 1'b0;
    end else begin
      if (pose_valid && pose_ready) begin
        pending_rates.push_back(pose_rate_of(pose));
        void'(pose_backlog.pop_front());
        head_loaded = 1'b0;
      end
      if (!pose_valid || pose_ready) begin
        if (pose_backlog.size() != 0) begin
          if (!head_loaded) begin
            send_idle = pose_backlog[0].idle;
            head_loaded = 1'b1;
          end
          if (send_idle > 0) begin
            send_idle--;
            pose_valid <= 1'b0;
          end else if (pose_backlog[0].drain && pending_rates.size() != 0) begin
            pose_valid <= 1'b0;
          end else begin
            pose_valid <= 1'b1;
            pose <= pose_backlog[0].pose;
          end
        end else begin
          pose_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken result against the oldest expectation and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      rate_ready <= 1'b0;
    end else begin
      if (rate_valid && rate_ready) begin
        results_seen++;
        if (pending_rates.size() == 0) begin
          $display("%0t ERROR: unexpected result, expected none, actual %h", $time, rate);
          mismatches++;
        end else begin
          want_rate = pending_rates.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (want_rate[32*i +: 32] !== rate[32*i +: 32]) begin
              $display("%0t ERROR: %s expected %h actual %h", $time, rate_field[i],
                       want_rate[32*i +: 32], rate[32*i +: 32]);
              mismatches++;
            end
          end
        end
        // Long hold-off so the pipeline fills and back-pressures the sender.
        if (results_seen == 150 || results_seen == 800) stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        rate_ready <= 1'b0;
      end else begin
        rate_ready <= 1'b1;
        if ((results_seen / 64) % 4 != 0) stall_left = pick_idle();
      end
    end
  end

  // Watchdog on cycles without any item moving on either side.
  always @(posedge clk) begin
    if (rst || (pose_valid && pose_ready) || (rate_valid && rate_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    pose_t p;
    int unsigned r;

    // Directed items: zero, identity, extremes, rounding ties, non-unit quaternions.
    p = '{'0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
    queue_pose(p, 1'b0);
    p = '{QOne, '0, '0, '0, VOne, VOne << 1, -(VOne * 3), VOne, -(VOne >> 1), VOne >> 2};
    queue_pose(p, 1'b0);
    p = '{QOne, '0, '0, '0, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax};
    queue_pose(p, 1'b0);
    p = '{QOne, '0, '0, '0, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin};
    queue_pose(p, 1'b0);
    p = '{WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, WordMax,
          WordMax};
    queue_pose(p, 1'b0);
    p = '{WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, WordMin,
          WordMin};
    queue_pose(p, 1'b0);
    p = '{WordMin, WordMin, WordMin, WordMin, WordMax, WordMax, WordMax, WordMax, WordMax,
          WordMax};
    queue_pose(p, 1'b0);
    // Quaternion rate exactly half an LSB, positive and negative.
    p = '{QOne, '0, '0, '0, '0, '0, '0, 32'h1, '0, '0};
    queue_pose(p, 1'b0);
    p = '{QOne, '0, '0, '0, '0, '0, '0, WordOnes, '0, '0};
    queue_pose(p, 1'b0);
    // Position rate exactly half an LSB, positive and negative.
    p = '{'0, QHalf, QHalf, '0, '0, 32'h1, '0, '0, '0, '0};
    queue_pose(p, 1'b0);
    p = '{'0, QHalf, QHalf, '0, '0, WordOnes, '0, '0, '0, '0};
    queue_pose(p, 1'b0);
    // Quaternion of length two, not normalized.
    p = '{QOne, QOne, QOne, QOne, VOne, -VOne, VOne << 4, VOne, VOne, -VOne};
    queue_pose(p, 1'b0);
    // Quarter turn about z and half turn about x.
    p = '{QDiag, '0, '0, QDiag, VOne, '0, '0, '0, '0, VOne};
    queue_pose(p, 1'b0);
    p = '{'0, QOne, '0, '0, VOne, VOne, VOne, VOne, VOne, VOne};
    queue_pose(p, 1'b0);
    p = '{WordOnes, WordOnes, WordOnes, WordOnes, WordOnes, WordOnes, WordOnes, WordOnes,
          WordOnes, WordOnes};
    queue_pose(p, 1'b0);
    p = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
    queue_pose(p, 1'b0);
    // Negated most negative part feeds the rate matrix.
    p = '{'0, WordMin, WordMin, WordMin, '0, '0, '0, WordMin, WordMin, WordMin};
    queue_pose(p, 1'b0);
    p = '{WordMax, WordMin, WordMax, WordMin, WordMin, WordMax, WordMin, WordMax, WordMin,
          WordMax};
    queue_pose(p, 1'b0);

    // Random items: mostly parts up to 1.0 with moderate rates, else raw or mixed words.
    for (int unsigned n = 0; n < RandomPoses; n++) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        p.quat_s = rand_word(WordUnit);
        p.quat_x = rand_word(WordUnit);
        p.quat_y = rand_word(WordUnit);
        p.quat_z = rand_word(WordUnit);
        p.lin_vel_x = rand_word(WordSmall);
        p.lin_vel_y = rand_word(WordSmall);
        p.lin_vel_z = rand_word(WordSmall);
        p.ang_vel_x = rand_word(WordSmall);
        p.ang_vel_y = rand_word(WordSmall);
        p.ang_vel_z = rand_word(WordSmall);
      end else if (r < 85) begin
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      end else begin
        p.quat_s = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.quat_x = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.quat_y = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.quat_z = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.lin_vel_x = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.lin_vel_y = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.lin_vel_z = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.ang_vel_x = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.ang_vel_y = rand_word(word_kind_e'($urandom_range(0, 3)));
        p.ang_vel_z = rand_word(word_kind_e'($urandom_range(0, 3)));
      end
      // The sender waits for the pipeline to empty before the first random item and
      // once midway.
      queue_pose(p, n == 0 || n == DrainPoint);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pose_backlog.size() != 0 || pending_rates.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/qpr_pkg.sv
sv/qpr_rot_dot.sv
sv/quaternion_pose_rate_unit.sv
tb/sv/tb.sv
